[design/fmpnc_pkg.sv]
// fmpnc_pkg: shared types and constants for the frame mix / normalize / compress block
// no dependencies
`timescale 1ns / 1ps

package fmpnc_pkg;

   localparam int MaxFrameSamples = 2048;
   localparam int AddrWidth       = $clog2(MaxFrameSamples);
   localparam int CountWidth      = AddrWidth + 1;
   localparam int SampleWidth     = 20;
   localparam int OutWidth        = 18;
   localparam int MagWidth        = 20;
   localparam int QueueDepth      = 4;
   localparam int QueueAddrWidth  = $clog2(QueueDepth);
   // dividend width for a*65536 + peak/2
   localparam int DivWidth        = 37;

   localparam logic [2:0] CsrNormalize = 3'd0;
   localparam logic [2:0] CsrCompress  = 3'd1;
   localparam logic [2:0] CsrThreshold = 3'd2;
   localparam logic [2:0] CsrRatio     = 3'd3;

   typedef struct packed {
      logic                    cmd;
      logic signed [19:0]      mix_sample;
      logic signed [19:0]      acc_sample;
   } req_type;

   typedef struct packed {
      logic signed [17:0]      out_sample;
      logic                    frame_end;
      logic                    peak_scaled;
   } rsp_type;

   // job handed from front to back: one stored sample to condition
   typedef struct packed {
      logic signed [SampleWidth-1:0] sample;
      logic [MagWidth-1:0]           peak;
      logic                          last;
   } job_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_DIV1,
      BACK_CHECK,
      BACK_DIV2,
      BACK_EMIT
   } back_state_type;

endpackage

[design/fmpnc_front.sv]
// fmpnc_front: accepts items, keeps the frame store, peak and counters, issues drain jobs
// depends on fmpnc_pkg
`timescale 1ns / 1ps

module fmpnc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  fmpnc_pkg::req_type   req_data,
   input  logic                 job_full,
   output logic                 job_push,
   output fmpnc_pkg::job_type   job_data
);

   logic signed [fmpnc_pkg::SampleWidth-1:0] store [fmpnc_pkg::MaxFrameSamples];
   logic [fmpnc_pkg::CountWidth-1:0] fill_ff, fill_in, rd_ff, rd_in;
   logic [fmpnc_pkg::MagWidth-1:0]   peak_ff, peak_in;
   logic                             pend_ff, pend_in;
   logic                             last_ff, last_in;
   logic [fmpnc_pkg::MagWidth-1:0]   jpeak_ff, jpeak_in;
   logic signed [fmpnc_pkg::SampleWidth-1:0] rdata_ff;
   logic signed [fmpnc_pkg::SampleWidth:0]   sum_w;
   logic signed [fmpnc_pkg::SampleWidth-1:0] sat;
   logic [fmpnc_pkg::MagWidth-1:0]           mag;
   logic accept, load_ok, drain_ok;

   // one drain in flight until its store read lands in the job queue
   assign req_full = pend_ff;
   assign accept   = req_push && !req_full;
   assign sum_w    = {req_data.mix_sample[19], req_data.mix_sample}
                   + {req_data.acc_sample[19], req_data.acc_sample};
   assign load_ok  = accept && !req_data.cmd
                   && (fill_ff != fmpnc_pkg::CountWidth'(fmpnc_pkg::MaxFrameSamples));
   assign drain_ok = accept && req_data.cmd && (rd_ff < fill_ff);

   always_comb begin
      if (sum_w > 21'sd524287) begin
         sat = 20'sd524287;
      end else if (sum_w < -21'sd524288) begin
         sat = -20'sd524288;
      end else begin
         sat = sum_w[19:0];
      end
      mag = sat[19] ? 20'(-{sat[19], sat}) : sat;
   end

   always_comb begin
      fill_in  = fill_ff;
      rd_in    = rd_ff;
      peak_in  = peak_ff;
      pend_in  = pend_ff;
      last_in  = last_ff;
      jpeak_in = jpeak_ff;
      if (pend_ff && !job_full) begin
         pend_in = 1'b0;
      end
      if (load_ok) begin
         fill_in = fill_ff + 1'b1;
         if (mag > peak_ff) begin
            peak_in = mag;
         end
      end
      if (drain_ok) begin
         pend_in  = 1'b1;
         jpeak_in = peak_ff;
         last_in  = (rd_ff + 1'b1) == fill_ff;
         if ((rd_ff + 1'b1) == fill_ff) begin
            fill_in = '0;
            rd_in   = '0;
            peak_in = '0;
         end else begin
            rd_in = rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok) begin
         store[fill_ff[fmpnc_pkg::AddrWidth-1:0]] <= sat;
      end
      if (drain_ok) begin
         rdata_ff <= store[rd_ff[fmpnc_pkg::AddrWidth-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rd_ff   <= '0;
         peak_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         rd_ff   <= rd_in;
         peak_ff <= peak_in;
         pend_ff <= pend_in;
      end
      last_ff  <= last_in;
      jpeak_ff <= jpeak_in;
   end

   assign job_push        = pend_ff && !job_full;
   assign job_data.sample = rdata_ff;
   assign job_data.peak   = jpeak_ff;
   assign job_data.last   = last_ff;

   a_rd_le_fill: assert property (@(posedge clock) disable iff (reset) rd_ff <= fill_ff)
      else $error("read index passed fill count");
   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= fmpnc_pkg::CountWidth'(fmpnc_pkg::MaxFrameSamples))
      else $error("fill count overflow");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      drain_ok && last_in |=> fill_ff == '0 && peak_ff == '0)
      else $error("frame not cleared after last drain");

endmodule

[design/fmpnc_queue.sv]
// fmpnc_queue: short fifo of drain jobs between front and back
// depends on fmpnc_pkg
`timescale 1ns / 1ps

module fmpnc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fmpnc_pkg::job_type   push_data,
   output logic                 full,
   input  logic                 pop,
   output fmpnc_pkg::job_type   pop_data,
   output logic                 empty
);

   fmpnc_pkg::job_type slot_ff [fmpnc_pkg::QueueDepth];
   logic [fmpnc_pkg::QueueAddrWidth-1:0] wp_ff, rp_ff;
   logic [fmpnc_pkg::QueueAddrWidth:0]   cnt_ff;

   assign full     = cnt_ff == (fmpnc_pkg::QueueAddrWidth+1)'(fmpnc_pkg::QueueDepth);
   assign empty    = cnt_ff == '0;
   assign pop_data = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop && !empty) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (push && !full) - (pop && !empty);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !(pop && !empty) |=> full)
      else $error("queue count lost");
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (fmpnc_pkg::QueueAddrWidth+1)'(fmpnc_pkg::QueueDepth))
      else $error("queue count out of range");
   a_empty_full: assert property (@(posedge clock) disable iff (reset) !(empty && full))
      else $error("queue both empty and full");

endmodule

[design/fmpnc_back.sv]
// fmpnc_back: conditions one sample with a shared serial divider, holds the result
// depends on fmpnc_pkg
`timescale 1ns / 1ps

module fmpnc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 normalize_enable,
   input  logic                 compress_enable,
   input  logic [16:0]          comp_threshold,
   input  logic [15:0]          comp_ratio,
   input  logic                 job_empty,
   input  fmpnc_pkg::job_type   job_data,
   output logic                 job_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output fmpnc_pkg::rsp_type   rsp_data
);

   fmpnc_pkg::back_state_type state_ff, state_in;
   logic [fmpnc_pkg::DivWidth-1:0] quo_ff, quo_in;     // dividend shifting into quotient
   logic [20:0]    rem_ff, rem_in;
   logic [19:0]    div_ff, div_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [16:0]    a_ff, a_in;
   logic           neg_ff, neg_in, last_ff, last_in, scl_ff, scl_in;
   logic           have_ff, have_in;
   fmpnc_pkg::rsp_type out_ff, out_in;
   logic [19:0]    mag;
   logic [20:0]    trial;
   logic [15:0]    ratio;
   logic [16:0]    exc;
   logic           start;
   // keeps whether the unclamped magnitude went above 17 bits
   logic           mag_hi_ff;

   assign mag   = job_data.sample[19] ? 20'(-job_data.sample) : job_data.sample;
   assign ratio = (comp_ratio < 16'd256) ? 16'd256 : comp_ratio;
   assign exc   = a_ff - comp_threshold;
   assign trial = {rem_ff[19:0], quo_ff[fmpnc_pkg::DivWidth-1]} - {1'b0, div_ff};
   assign start = state_ff == fmpnc_pkg::BACK_IDLE;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fmpnc_pkg::BACK_IDLE: begin
            if (!job_empty) begin
               if (normalize_enable && job_data.peak > 20'd65536) begin
                  state_in = fmpnc_pkg::BACK_DIV1;
               end else begin
                  state_in = fmpnc_pkg::BACK_CHECK;
               end
            end
         end
         fmpnc_pkg::BACK_DIV1: begin
            if (cnt_ff == 6'd0) begin
               state_in = fmpnc_pkg::BACK_CHECK;
            end
         end
         fmpnc_pkg::BACK_CHECK: begin
            if (normalize_enable && compress_enable && {3'b0, a_ff} > {3'b0, comp_threshold}) begin
               state_in = fmpnc_pkg::BACK_DIV2;
            end else begin
               state_in = fmpnc_pkg::BACK_EMIT;
            end
         end
         fmpnc_pkg::BACK_DIV2: begin
            if (cnt_ff == 6'd0) begin
               state_in = fmpnc_pkg::BACK_EMIT;
            end
         end
         fmpnc_pkg::BACK_EMIT: begin
            if (!have_ff || rsp_pop) begin
               state_in = fmpnc_pkg::BACK_IDLE;
            end
         end
         default: state_in = fmpnc_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      neg_in  = neg_ff;
      last_in = last_ff;
      scl_in  = scl_ff;
      have_in = have_ff;
      out_in  = out_ff;
      job_pop = 1'b0;
      if (have_ff && rsp_pop) begin
         have_in = 1'b0;
      end
      case (state_ff)
         fmpnc_pkg::BACK_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               neg_in  = job_data.sample[19];
               last_in = job_data.last;
               scl_in  = 1'b0;
               a_in    = mag[16:0];
               if (normalize_enable && job_data.peak > 20'd65536) begin
                  scl_in = 1'b1;
                  quo_in = {1'b0, mag, 16'd0}
                         + fmpnc_pkg::DivWidth'(job_data.peak[19:1]);
                  rem_in = '0;
                  div_in = job_data.peak;
                  cnt_in = 6'(fmpnc_pkg::DivWidth - 1);
               end
            end
         end
         fmpnc_pkg::BACK_DIV1, fmpnc_pkg::BACK_DIV2: begin
            if (!trial[20]) begin
               rem_in = trial;
               quo_in = {quo_ff[fmpnc_pkg::DivWidth-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[19:0], quo_ff[fmpnc_pkg::DivWidth-1]};
               quo_in = {quo_ff[fmpnc_pkg::DivWidth-2:0], 1'b0};
            end
            if (cnt_ff == 6'd0) begin
               if (state_ff == fmpnc_pkg::BACK_DIV1) begin
                  a_in = quo_in[16:0];
               end else begin
                  a_in = comp_threshold + quo_in[16:0];
               end
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         fmpnc_pkg::BACK_CHECK: begin
            if (!normalize_enable) begin
               // plain clamp to +-1.0 on the magnitude
               if (a_ff > 17'd65536 || mag_hi_ff) begin
                  a_in = 17'd65536;
               end
            end
            quo_in = fmpnc_pkg::DivWidth'({exc, 8'd0}) + fmpnc_pkg::DivWidth'(ratio[15:1]);
            rem_in = '0;
            div_in = {4'd0, ratio};
            cnt_in = 6'(fmpnc_pkg::DivWidth - 1);
         end
         fmpnc_pkg::BACK_EMIT: begin
            if (!have_ff || rsp_pop) begin
               have_in            = 1'b1;
               out_in.out_sample  = neg_ff ? -$signed({1'b0, a_ff}) : $signed({1'b0, a_ff});
               out_in.frame_end   = last_ff;
               out_in.peak_scaled = scl_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (start && !job_empty) begin
         mag_hi_ff <= |mag[19:17];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fmpnc_pkg::BACK_IDLE;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         have_ff  <= have_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      neg_ff  <= neg_in;
      last_ff <= last_in;
      scl_ff  <= scl_in;
      out_ff  <= out_in;
   end

   assign rsp_empty = !have_ff;
   assign rsp_data  = out_ff;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> state_ff == fmpnc_pkg::BACK_IDLE)
      else $error("job taken while busy");
   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      state_ff == fmpnc_pkg::BACK_EMIT && !have_ff |=> have_ff)
      else $error("result not registered");
   a_range: assert property (@(posedge clock) disable iff (reset)
      have_ff |-> out_ff.out_sample <= 18'sd65536 && out_ff.out_sample >= -18'sd65536)
      else $error("result out of range");

endmodule

[design/frame_mix_peak_normalize_compress.sv]
// frame_mix_peak_normalize_compress: top level, config registers and wiring of front, queue, back
// depends on fmpnc_pkg, fmpnc_front, fmpnc_queue, fmpnc_back
`timescale 1ns / 1ps

// Load beats add mix and accumulator samples, saturate to Q4.16 and append to a
// 2048-entry frame store while tracking the peak. Drain beats read samples back
// in load order and hand them through a four-entry job queue to a back end that
// clamps, or normalizes by 1/peak and optionally compresses. The back end uses one
// bit-serial divider of 37 steps, run once for normalizing and once for
// compression, and takes a new job only once the last result is registered, so a
// result waits behind earlier jobs or a result not yet popped. The divider sets
// the drain rate. Input is held off after each drain while its store read is
// handed on, and for as long as the job queue stays full. No clearing pass: the
// store is guarded by a fill count.

module frame_mix_peak_normalize_compress (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  fmpnc_pkg::req_type   req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output fmpnc_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [16:0]          csr_data
);

   logic        norm_ff, comp_ff;
   logic [16:0] thr_ff;
   logic [15:0] ratio_ff;
   logic        jq_push, jq_full, jq_pop, jq_empty;
   fmpnc_pkg::job_type jq_in, jq_out;

   // config writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff  <= 1'b0;
         comp_ff  <= 1'b0;
         thr_ff   <= 17'd52429;
         ratio_ff <= 16'd1024;
      end else if (csr_valid) begin
         case (csr_index)
            fmpnc_pkg::CsrNormalize: norm_ff  <= csr_data[0];
            fmpnc_pkg::CsrCompress:  comp_ff  <= csr_data[0];
            fmpnc_pkg::CsrThreshold: thr_ff   <= csr_data;
            fmpnc_pkg::CsrRatio:     ratio_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   fmpnc_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .job_full(jq_full), .job_push(jq_push), .job_data(jq_in)
   );

   fmpnc_queue u_queue (
      .clock(clock), .reset(reset),
      .push(jq_push), .push_data(jq_in), .full(jq_full),
      .pop(jq_pop), .pop_data(jq_out), .empty(jq_empty)
   );

   fmpnc_back u_back (
      .clock(clock), .reset(reset),
      .normalize_enable(norm_ff), .compress_enable(comp_ff),
      .comp_threshold(thr_ff), .comp_ratio(ratio_ff),
      .job_empty(jq_empty), .job_data(jq_out), .job_pop(jq_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

endmodule
